>>> rtl/core/gdmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gdmc_pkg;

  localparam int unsigned DataW = 104;

  // day length in ms is DAY_Q << 10
  localparam logic [16:0] DAY_Q      = 17'd84375;
  localparam logic [17:0] DAYS_400Y  = 18'd146097;
  localparam logic [15:0] DAYS_100Y  = 16'd36524;
  localparam logic [10:0] DAYS_4Y    = 11'd1461;
  localparam logic [8:0]  DAYS_1Y    = 9'd365;
  localparam logic [48:0] MAX_MS     = 49'd315537897599999;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;

  // scaled reciprocals; rounded down, so an estimate is low by at most one
  localparam logic [22:0] RCP_DAY    = 23'((64'd1 << 39) / 64'd84375);
  localparam logic [17:0] RCP_125    = 18'((1 << 24) / 125);
  localparam logic [4:0]  RCP_400Y   = 5'((1 << 22) / 146097);
  localparam logic [11:0] RCP_15S    = 12'((1 << 15) / 15);
  localparam logic [2:0]  RCP_100Y   = 3'((1 << 18) / 36524);
  localparam logic [5:0]  RCP_15M    = 6'((1 << 9) / 15);
  localparam logic [5:0]  RCP_4Y     = 6'((1 << 16) / 1461);
  localparam logic [2:0]  RCP_1Y     = 3'((1 << 11) / 365);
  // rounded up; exact for x < 4681
  localparam logic [11:0] RCP_25     = 12'(((1 << 16) + 24) / 25);

  typedef struct packed {
    logic        mode;
    logic        err;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  milli;
    logic [48:0] total;
    logic [2:0]  wd;
    logic [13:0] pm1;
    logic [38:0] num;
    logic [9:0]  lo10;
    logic [41:0] rph;
    logic [22:0] rpl;
    logic [21:0] qd;
    logic [6:0]  c100;
    logic [6:0]  y100;
    logic [38:0] mday;
    logic [26:0] tod;
    logic [23:0] xsec;
    logic [2:0]  low3;
    logic [16:0] secd;
    logic [4:0]  q400;
    logic [17:0] d400;
    logic [10:0] mod;
    logic [2:0]  cyc;
    logic [15:0] d100;
    logic [4:0]  q4;
    logic [10:0] d4;
    logic [2:0]  yy;
    logic [8:0]  doy;
    logic        lp;
  } pipe_t;

  // days before month idx+1 (idx 0..12)
  function automatic logic [8:0] cum_days(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd365;
    endcase
    return base + 9'(leap && (idx >= 4'd2));
  endfunction

  // 8 == 1 mod 7: fold octal digits
  function automatic logic [2:0] mod7(input logic [21:0] x);
    logic [23:0] xp;
    logic [5:0]  s;
    logic [3:0]  f;
    xp = {2'b00, x};
    s  = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 6'(xp[3*i +: 3]);
    end
    f = 4'(s[5:3]) + 4'(s[2:0]);
    if (f >= 4'd14) begin
      f = f - 4'd14;
    end else if (f >= 4'd7) begin
      f = f - 4'd7;
    end
    return f[2:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/gregorian_datetime_ms_converter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata (104 bits)                        tuser
// s_axis    in   year,month,day,hour,minute,second,      mode
//                milli,total_ms
// m_axis    out  year,month,day,hour,minute,second,      range_error
//                milli,total_ms,weekday
//
// One item per cycle, unless m_axis stalls, through 14 register stages. The stages
// are the capture stage, a four-stage reciprocal division of the ms count by the day
// length, and nine stages of calendar arithmetic.
// Reset clears the stage valid bits only; no state survives between items.
// A stall on m_axis holds every stage; s_axis_tready_o drops in the same cycle.
module gregorian_datetime_ms_converter_unit import gdmc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [13:0] year, [17:14] month, [22:18] day, [27:23] hour, [33:28] minute,
  // [39:34] second, [49:40] milli, [98:50] total_ms, [103:99] zero
  input  wire logic [DataW-1:0] s_axis_tdata_i,
  // [0] mode
  input  wire logic             s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // [13:0] year, [17:14] month, [22:18] day, [27:23] hour, [33:28] minute,
  // [39:34] second, [49:40] milli, [98:50] total_ms, [101:99] weekday,
  // [103:102] zero
  output logic [DataW-1:0]      m_axis_tdata_o,
  // [0] range_error
  output logic                  m_axis_tuser_o
);

  localparam int NDIV = 4;
  localparam int S_PA = NDIV + 1;
  localparam int S_PB = NDIV + 2;
  localparam int S_PC = NDIV + 3;
  localparam int S_PD = NDIV + 4;
  localparam int S_PE = NDIV + 5;
  localparam int S_PF = NDIV + 6;
  localparam int S_PG = NDIV + 7;
  localparam int S_PH = NDIV + 8;
  localparam int S_PI = NDIV + 9;
  localparam int NST  = NDIV + 10;

  pipe_t           st_q [NST];
  pipe_t           st_d [NST];
  logic [NST-1:0]  vld_q;
  logic            en;

  assign en              = !vld_q[NST-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[NST-1];
  assign m_axis_tuser_o  = st_q[NST-1].err;
  assign m_axis_tdata_o  = {2'b00, st_q[NST-1].wd, st_q[NST-1].total, st_q[NST-1].milli,
                            st_q[NST-1].second, st_q[NST-1].minute, st_q[NST-1].hour,
                            st_q[NST-1].day, st_q[NST-1].month, st_q[NST-1].year};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st_d;
    end
  end

  // capture: clamp the date fields, split the ms count
  always_comb begin
    pipe_t       nx;
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [48:0] t;
    nx = '0;
    y  = s_axis_tdata_i[13:0];
    m  = s_axis_tdata_i[17:14];
    d  = s_axis_tdata_i[22:18];
    t  = s_axis_tdata_i[98:50];
    if (y == '0) begin
      y = 14'd1;
    end else if (y > YEAR_MAX) begin
      y = YEAR_MAX;
    end
    if (m == '0) begin
      m = 4'd1;
    end else if (m > MONTH_MAX) begin
      m = MONTH_MAX;
    end
    if (d == '0) begin
      d = 5'd1;
    end
    nx.mode   = s_axis_tuser_i;
    nx.err    = s_axis_tuser_i && (t > MAX_MS);
    nx.year   = y;
    nx.month  = m;
    nx.day    = d;
    nx.hour   = s_axis_tdata_i[27:23];
    nx.minute = s_axis_tdata_i[33:28];
    nx.second = s_axis_tdata_i[39:34];
    nx.milli  = s_axis_tdata_i[49:40];
    nx.total  = s_axis_tuser_i ? t : '0;
    nx.pm1    = y - 14'd1;
    nx.num    = t[48:10];
    nx.lo10   = t[9:0];
    st_d[0]   = nx;
  end

  // day count estimate: partial products of the count in units of 1024 ms
  always_comb begin
    pipe_t       nx;
    logic [42:0] pl;
    nx      = st_q[0];
    pl      = 43'(nx.num[19:0]) * 43'(RCP_DAY);
    nx.rph  = 42'(nx.num[38:20]) * 42'(RCP_DAY);
    nx.rpl  = pl[42:20];
    st_d[1] = nx;
  end

  // combine the partial products
  always_comb begin
    pipe_t       nx;
    logic [42:0] est;
    nx      = st_q[1];
    est     = 43'(nx.rph) + 43'(nx.rpl);
    nx.qd   = est[40:19];
    st_d[2] = nx;
  end

  // remainder of the estimate
  always_comb begin
    pipe_t nx;
    nx      = st_q[2];
    nx.num  = nx.num - 39'(nx.qd) * 39'(DAY_Q);
    st_d[3] = nx;
  end

  // fix the day count
  always_comb begin
    pipe_t nx;
    nx = st_q[3];
    if (nx.num >= 39'(DAY_Q)) begin
      nx.num = nx.num - 39'(DAY_Q);
      nx.qd  = nx.qd + 22'd1;
    end
    st_d[4] = nx;
  end

  // century estimates (fields mode); ms-of-day, 400-year estimates and weekday (count mode)
  always_comb begin
    pipe_t       nx;
    logic [23:0] pr;
    logic [23:0] yr;
    logic [26:0] r27;
    logic [41:0] sp;
    logic [26:0] qp;
    nx  = st_q[S_PA-1];
    pr  = 24'(nx.pm1[13:2]) * 24'(RCP_25);
    yr  = 24'(nx.year[13:2]) * 24'(RCP_25);
    r27 = {nx.num[16:0], nx.lo10};
    sp  = 42'(r27[26:3]) * 42'(RCP_125);
    qp  = 27'(nx.qd) * 27'(RCP_400Y);
    if (!nx.mode) begin
      nx.c100 = pr[22:16];
      nx.y100 = yr[22:16];
    end else begin
      nx.xsec = r27[26:3];
      nx.low3 = r27[2:0];
      nx.secd = sp[40:24];
      nx.q400 = qp[26:22];
      nx.wd   = mod7(nx.qd);
    end
    st_d[S_PA] = nx;
  end

  // day count (fields mode); fix second and 400-year quotients (count mode)
  always_comb begin
    pipe_t       nx;
    logic        leap;
    logic [21:0] days;
    logic [23:0] rs;
    logic [21:0] r4;
    nx   = st_q[S_PB-1];
    leap = (nx.year[1:0] == 2'b00) &&
           ((12'(nx.y100) * 12'd25 != nx.year[13:2]) || (nx.y100[1:0] == 2'b00));
    days = 22'(nx.pm1) * 22'(DAYS_1Y) + 22'(nx.pm1[13:2]) - 22'(nx.c100)
         + 22'(nx.c100[6:2]) + 22'(cum_days(nx.month - 4'd1, leap))
         + 22'(nx.day) - 22'd1;
    rs   = nx.xsec - 24'(nx.secd) * 24'd125;
    r4   = nx.qd - 22'(nx.q400) * 22'(DAYS_400Y);
    if (!nx.mode) begin
      nx.qd = days;
    end else begin
      if (rs >= 24'd125) begin
        rs      = rs - 24'd125;
        nx.secd = nx.secd + 17'd1;
      end
      if (r4 >= 22'(DAYS_400Y)) begin
        r4      = r4 - 22'(DAYS_400Y);
        nx.q400 = nx.q400 + 5'd1;
      end
      nx.milli = {rs[6:0], nx.low3};
      nx.d400  = r4[17:0];
    end
    st_d[S_PB] = nx;
  end

  // day product, time of day and weekday (fields mode); minute and century estimates
  always_comb begin
    pipe_t       nx;
    logic [26:0] mp;
    logic [20:0] cp;
    nx = st_q[S_PC-1];
    mp = 27'(nx.secd[16:2]) * 27'(RCP_15S);
    cp = 21'(nx.d400) * 21'(RCP_100Y);
    if (!nx.mode) begin
      nx.mday = 39'(nx.qd) * 39'(DAY_Q);
      nx.tod  = 27'(nx.hour) * 27'd3600000 + 27'(nx.minute) * 27'd60000
              + 27'(nx.second) * 27'd1000 + 27'(nx.milli);
      nx.wd   = mod7(nx.qd);
    end else begin
      nx.mod = mp[25:15];
      nx.cyc = cp[20:18];
    end
    st_d[S_PC] = nx;
  end

  // total ms (fields mode); fix minute-of-day and century (count mode)
  always_comb begin
    pipe_t       nx;
    logic [14:0] rr;
    logic [17:0] rc;
    nx = st_q[S_PD-1];
    rr = nx.secd[16:2] - 15'(nx.mod) * 15'd15;
    rc = nx.d400 - 18'(nx.cyc) * 18'(DAYS_100Y);
    if (!nx.mode) begin
      nx.total = {nx.mday, 10'b0} + 49'(nx.tod);
    end else begin
      if (rr >= 15'd15) begin
        rr     = rr - 15'd15;
        nx.mod = nx.mod + 11'd1;
      end
      if (rc >= 18'(DAYS_100Y)) begin
        rc     = rc - 18'(DAYS_100Y);
        nx.cyc = nx.cyc + 3'd1;
      end
      // last day of a 400-year cycle stays in the fourth century
      if (nx.cyc == 3'd4) begin
        nx.cyc = 3'd3;
        rc     = rc + 18'(DAYS_100Y);
      end
      nx.second = {rr[3:0], nx.secd[1:0]};
      nx.d100   = rc[15:0];
    end
    st_d[S_PD] = nx;
  end

  // hour and 4-year estimates
  always_comb begin
    pipe_t       nx;
    logic [14:0] hp;
    logic [21:0] qp;
    nx = st_q[S_PE-1];
    hp = 15'(nx.mod[10:2]) * 15'(RCP_15M);
    qp = 22'(nx.d100) * 22'(RCP_4Y);
    if (nx.mode) begin
      nx.hour = hp[13:9];
      nx.q4   = qp[20:16];
    end
    st_d[S_PE] = nx;
  end

  // fix hour and 4-year quotient
  always_comb begin
    pipe_t       nx;
    logic [8:0]  rr;
    logic [15:0] r4;
    nx = st_q[S_PF-1];
    rr = nx.mod[10:2] - 9'(nx.hour) * 9'd15;
    r4 = nx.d100 - 16'(nx.q4) * 16'(DAYS_4Y);
    if (nx.mode) begin
      if (rr >= 9'd15) begin
        rr      = rr - 9'd15;
        nx.hour = nx.hour + 5'd1;
      end
      if (r4 >= 16'(DAYS_4Y)) begin
        r4    = r4 - 16'(DAYS_4Y);
        nx.q4 = nx.q4 + 5'd1;
      end
      nx.minute = {rr[3:0], nx.mod[1:0]};
      nx.d4     = r4[10:0];
    end
    st_d[S_PF] = nx;
  end

  // year-in-group estimate
  always_comb begin
    pipe_t       nx;
    logic [13:0] yp;
    nx = st_q[S_PG-1];
    yp = 14'(nx.d4) * 14'(RCP_1Y);
    if (nx.mode) begin
      nx.yy = yp[13:11];
    end
    st_d[S_PG] = nx;
  end

  // fix year-in-group, assemble year and leap flag
  always_comb begin
    pipe_t       nx;
    logic [10:0] ry;
    nx = st_q[S_PH-1];
    ry = nx.d4 - 11'(nx.yy) * 11'(DAYS_1Y);
    if (nx.mode) begin
      if (ry >= 11'(DAYS_1Y)) begin
        ry    = ry - 11'(DAYS_1Y);
        nx.yy = nx.yy + 3'd1;
      end
      // last day of a leap group stays in its fourth year
      if (nx.yy == 3'd4) begin
        nx.yy = 3'd3;
        ry    = ry + 11'(DAYS_1Y);
      end
      nx.doy  = ry[8:0];
      nx.lp   = (nx.yy == 3'd3) && ((nx.q4 != 5'd24) || (nx.cyc == 3'd3));
      nx.year = 14'd1 + 14'(nx.q400) * 14'd400 + 14'(nx.cyc) * 14'd100
              + 14'(nx.q4) * 14'd4 + 14'(nx.yy);
    end
    st_d[S_PH] = nx;
  end

  // month lookup; zero the fields of an out-of-range count
  always_comb begin
    pipe_t       nx;
    logic [3:0]  mo;
    logic [8:0]  dy;
    nx = st_q[S_PI-1];
    mo = MONTH_MAX;
    dy = nx.doy - cum_days(4'd11, nx.lp) + 9'd1;
    for (int i = 12; i >= 1; i--) begin
      if (nx.doy < cum_days(4'(i), nx.lp)) begin
        mo = 4'(i);
        dy = nx.doy - cum_days(4'(i - 1), nx.lp) + 9'd1;
      end
    end
    if (nx.mode) begin
      nx.month = mo;
      nx.day   = dy[4:0];
      if (nx.err) begin
        nx.year   = '0;
        nx.month  = '0;
        nx.day    = '0;
        nx.hour   = '0;
        nx.minute = '0;
        nx.second = '0;
        nx.milli  = '0;
        nx.wd     = '0;
      end
    end
    st_d[S_PI] = nx;
  end

endmodule

`default_nettype wire

>>> rtl/core/gdmc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gdmc_checker import gdmc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid_i,
  input wire logic             s_axis_tready_o,
  input wire logic [DataW-1:0] s_axis_tdata_i,
  input wire logic             s_axis_tuser_i,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [DataW-1:0] m_axis_tdata_o,
  input wire logic             m_axis_tuser_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // input side advances exactly when the output slot frees
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output slot");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      (m_axis_tdata_o[49:0] == '0) && (m_axis_tdata_o[101:99] == '0))
    else $error("range error with nonzero fields");

  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      (m_axis_tdata_o[101:99] != 3'd7) && (m_axis_tdata_o[17:14] != 4'd0) &&
      (m_axis_tdata_o[17:14] <= MONTH_MAX) && (m_axis_tdata_o[22:18] != 5'd0))
    else $error("weekday, month or day out of range");

endmodule

bind gregorian_datetime_ms_converter_unit gdmc_checker u_gdmc_checker (.*);

`default_nettype wire
